// File: src/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// Base status frame receiver package
// Shared frame constants, status codes and the result record.
// ----------------------------------------------------------------------------
package bsfr_pkg;

    localparam int unsigned FRAME_LEN   = 22;
    localparam int unsigned STORE_LEN   = FRAME_LEN - 1;
    localparam int unsigned INDEX_W     = 5;
    localparam logic [7:0]  HEAD_BYTE   = 8'h23;
    localparam logic [7:0]  TAIL_BYTE   = 8'h32;
    localparam logic [INDEX_W-1:0] LAST_POS  = INDEX_W'(FRAME_LEN - 1);
    localparam logic [INDEX_W-1:0] CHECK_POS = INDEX_W'(FRAME_LEN - 2);
    localparam int unsigned RESULT_W    = 168;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_FRAMING  = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [15:0] fault_count;
        logic [7:0]  state_flags;
        logic [15:0] heading_offset;
        logic [31:0] right_delta;
        logic [31:0] left_delta;
        logic [7:0]  battery_level;
        logic [7:0]  bumper_bits;
        logic [47:0] ultrasonic_bytes;
    } result_data_t;

endpackage

// File: src/base_status_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Base status frame receiver
// Assembles 22-byte base status frames, checks head, tail and checksum, and
// reports sensor bytes, encoder deltas, relative heading and a fault count.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Width  Content
//  s_axis    in         8 + 1  tdata: rx_byte; tuser: frame_start
//  m_axis    out      168 + 2  tdata: result fields; tuser: frame_status
//
// One byte is taken in every cycle while s_tready is high; the result of the
// byte that closes or aborts a frame goes to an output register, or to a skid
// register while m_axis stalls; s_tready drops only when both are full.
// rst_n clears the frame position, the encoder and heading history and the
// fault count; stored frame bytes are always written before they are read.
module base_status_frame_receiver_unit
    import bsfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic                s_tuser,   // [0] frame_start
    output logic                m_tvalid,
    input  logic                m_tready,
    // [47:0] ultrasonic_bytes, [55:48] bumper_bits, [63:56] battery_level,
    // [95:64] left_delta, [127:96] right_delta, [143:128] heading_offset,
    // [151:144] state_flags, [167:152] fault_count
    output logic [RESULT_W-1:0] m_tdata,
    output logic [1:0]          m_tuser    // [1:0] frame_status
);

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]         frame_store_reg [STORE_LEN];
    logic [7:0]         running_sum_reg, running_sum_next;
    logic [1:0]         good_frames_reg, good_frames_next;
    logic [31:0]        prev_left_reg, prev_left_next;
    logic [31:0]        prev_right_reg, prev_right_next;
    logic [31:0]        left_hold_reg, left_hold_next;
    logic [31:0]        right_hold_reg, right_hold_next;
    logic [15:0]        heading_zero_reg, heading_zero_next;
    logic [15:0]        fault_total_reg, fault_total_next;

    logic               out_valid_reg, out_valid_next;
    result_data_t       out_data_reg, out_data_next;
    frame_status_t      out_status_reg, out_status_next;
    logic               skid_valid_reg, skid_valid_next;
    result_data_t       skid_data_reg, skid_data_next;
    frame_status_t      skid_status_reg, skid_status_next;

    logic               in_accept;
    logic               store_en;
    logic               res_valid;
    result_data_t       res_data;
    frame_status_t      res_status;
    frame_status_t      check_status;
    logic [31:0]        left_word;
    logic [31:0]        right_word;
    logic [15:0]        heading_word;
    logic [15:0]        fault_inc;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_status_reg;

    assign left_word    = {frame_store_reg[9], frame_store_reg[10],
                           frame_store_reg[11], frame_store_reg[12]};
    assign right_word   = {frame_store_reg[13], frame_store_reg[14],
                           frame_store_reg[15], frame_store_reg[16]};
    assign heading_word = {frame_store_reg[17], frame_store_reg[18]};
    assign fault_inc    = fault_total_reg + 16'd1;

    always_comb
    begin
        if (frame_store_reg[0] != HEAD_BYTE || s_tdata != TAIL_BYTE)
        begin
            check_status = STATUS_FRAMING;
        end
        else if (frame_store_reg[CHECK_POS] != running_sum_reg)
        begin
            check_status = STATUS_CHECKSUM;
        end
        else
        begin
            check_status = STATUS_GOOD;
        end
    end

    always_comb
    begin
        byte_index_next   = byte_index_reg;
        running_sum_next  = running_sum_reg;
        good_frames_next  = good_frames_reg;
        prev_left_next    = prev_left_reg;
        prev_right_next   = prev_right_reg;
        left_hold_next    = left_hold_reg;
        right_hold_next   = right_hold_reg;
        heading_zero_next = heading_zero_reg;
        fault_total_next  = fault_total_reg;
        store_en          = 1'b0;
        res_valid         = 1'b0;
        res_status        = STATUS_FRAMING;
        res_data          = '0;
        res_data.fault_count = fault_inc;

        if (in_accept)
        begin
            if (s_tuser)
            begin
                if (byte_index_reg != '0)
                begin
                    res_valid        = 1'b1;
                    fault_total_next = fault_inc;
                end
                store_en         = 1'b1;
                running_sum_next = '0;
                byte_index_next  = INDEX_W'(1);
            end
            else if (byte_index_reg == '0 || byte_index_reg > LAST_POS)
            begin
                byte_index_next = '0;
            end
            else if (byte_index_reg != LAST_POS)
            begin
                store_en        = 1'b1;
                byte_index_next = byte_index_reg + INDEX_W'(1);
                if (byte_index_reg != CHECK_POS)
                begin
                    running_sum_next = running_sum_reg + s_tdata;
                end
            end
            else
            begin
                byte_index_next = '0;
                res_valid       = 1'b1;
                res_status      = check_status;
                if (check_status != STATUS_GOOD)
                begin
                    fault_total_next = fault_inc;
                end
                else
                begin
                    if (good_frames_reg == 2'd2)
                    begin
                        left_hold_next  = left_word - prev_left_reg;
                        right_hold_next = prev_right_reg - right_word;
                    end
                    prev_left_next  = left_word;
                    prev_right_next = right_word;
                    if (good_frames_reg == 2'd0)
                    begin
                        heading_zero_next       = heading_word;
                        res_data.heading_offset = '0;
                    end
                    else
                    begin
                        res_data.heading_offset = heading_word - heading_zero_reg;
                    end
                    if (good_frames_reg != 2'd2)
                    begin
                        good_frames_next = good_frames_reg + 2'd1;
                    end
                    res_data.ultrasonic_bytes = {frame_store_reg[1], frame_store_reg[2],
                                                 frame_store_reg[3], frame_store_reg[4],
                                                 frame_store_reg[5], frame_store_reg[6]};
                    res_data.bumper_bits   = frame_store_reg[7];
                    res_data.battery_level = frame_store_reg[8];
                    res_data.left_delta    = left_hold_next;
                    res_data.right_delta   = right_hold_next;
                    res_data.state_flags   = frame_store_reg[19];
                    res_data.fault_count   = fault_total_reg;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_data_next   = skid_data_reg;
        skid_status_next = skid_status_reg;

        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_data_next    = skid_data_reg;
                out_status_next  = skid_status_reg;
                skid_valid_next  = res_valid;
                skid_data_next   = res_data;
                skid_status_next = res_status;
            end
            else
            begin
                out_valid_next  = res_valid;
                out_data_next   = res_data;
                out_status_next = res_status;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next  = 1'b1;
            skid_data_next   = res_data;
            skid_status_next = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            running_sum_reg  <= '0;
            good_frames_reg  <= '0;
            prev_left_reg    <= '0;
            prev_right_reg   <= '0;
            left_hold_reg    <= '0;
            right_hold_reg   <= '0;
            heading_zero_reg <= '0;
            fault_total_reg  <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            running_sum_reg  <= running_sum_next;
            good_frames_reg  <= good_frames_next;
            prev_left_reg    <= prev_left_next;
            prev_right_reg   <= prev_right_next;
            left_hold_reg    <= left_hold_next;
            right_hold_reg   <= right_hold_next;
            heading_zero_reg <= heading_zero_next;
            fault_total_reg  <= fault_total_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
        skid_data_reg   <= skid_data_next;
        skid_status_reg <= skid_status_next;
        if (store_en)
        begin
            if (s_tuser)
            begin
                frame_store_reg[0] <= s_tdata;
            end
            else
            begin
                frame_store_reg[byte_index_reg] <= s_tdata;
            end
        end
    end

endmodule

// File: tb/sv/tb_base_status_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Base status frame receiver testbench
// Sends 22-byte status frames byte by byte with random gaps, while the result
// side stalls on a pattern of its own. Each result is compared field by field
// with a predictor of the receiver. A directed table with the extremes and
// every fault comes first. Random frames follow, mostly well formed.
// ----------------------------------------------------------------------------
module tb_base_status_frame_receiver_unit
    import bsfr_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned ITEM_TARGET  = 1050;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum {
        KIND_GOOD,
        KIND_BAD_HEAD,
        KIND_BAD_TAIL,
        KIND_BAD_SUM,
        KIND_BAD_BOTH,
        KIND_CUT,
        KIND_STRAY,
        KIND_TRAILING
    } frame_kind_t;

    typedef struct {
        frame_kind_t   kind;
        int unsigned   len;
        logic [7:0]    fill;
        bit            rand_fill;
        logic [31:0]   left;
        logic [31:0]   right;
        logic [15:0]   heading;
        bit            typed;
        frame_status_t t_status;
        logic [15:0]   t_faults;
    } stim_row_t;

    typedef struct {
        frame_status_t status;
        result_data_t  data;
    } frame_result_t;

    typedef logic [7:0] frame_bytes_t [FRAME_LEN];

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    logic [4:0]  rx_pos      = '0;
    logic [7:0]  rx_copy [FRAME_LEN];
    logic [7:0]  rx_sum      = '0;
    logic [1:0]  good_seen   = '0;
    logic [31:0] last_left   = '0;
    logic [31:0] last_right  = '0;
    logic [31:0] left_hold   = '0;
    logic [31:0] right_hold  = '0;
    logic [15:0] heading_ref = '0;
    logic [15:0] fault_total = '0;

    frame_result_t pending_frames [$];
    int unsigned   mismatches    = 0;
    int unsigned   counted_bytes = 0;
    int unsigned   burst_left    = 0;
    int unsigned   cycle_count   = 0;
    bit            typed_on      = 1'b0;
    frame_status_t typed_status  = STATUS_GOOD;
    logic [15:0]   typed_faults  = '0;
    logic [31:0]   gen_left      = '0;
    logic [31:0]   gen_right     = '0;

    int unsigned   rdy_mode      = 0;
    int unsigned   rdy_left      = 0;
    int unsigned   rdy_phase     = 0;

    stim_row_t directed_rows [17] = '{
        '{KIND_STRAY,    4, 8'h00, 1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_GOOD,     0, 8'h00, 1'b0, 32'h0000_0000, 32'h0000_0000, 16'h1234,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_GOOD,     0, 8'hff, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 16'hffff,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_GOOD,     0, 8'h00, 1'b0, 32'h0000_0000, 32'h0000_0000, 16'h1233,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_GOOD,     0, 8'ha5, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 16'h9234,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_GOOD,     0, 8'h5a, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 16'h1234,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_BAD_HEAD, 0, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b1, STATUS_FRAMING, 16'd1},
        '{KIND_BAD_TAIL, 0, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b1, STATUS_FRAMING, 16'd2},
        '{KIND_BAD_SUM,  0, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b1, STATUS_CHECKSUM, 16'd3},
        '{KIND_BAD_BOTH, 0, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b1, STATUS_FRAMING, 16'd4},
        '{KIND_CUT,     10, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_GOOD,     0, 8'h00, 1'b1, 32'h1234_5678, 32'h8765_4321, 16'h4321,
          1'b1, STATUS_FRAMING, 16'd5},
        '{KIND_CUT,      1, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b0, STATUS_GOOD, 16'd0},
        '{KIND_CUT,     21, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b1, STATUS_FRAMING, 16'd6},
        '{KIND_TRAILING, 3, 8'h00, 1'b1, 32'h1234_0000, 32'h8765_0000, 16'hc321,
          1'b1, STATUS_FRAMING, 16'd7},
        '{KIND_BAD_SUM,  0, 8'h00, 1'b1, 32'h0000_0001, 32'h0000_0002, 16'h0003,
          1'b1, STATUS_CHECKSUM, 16'd8},
        '{KIND_GOOD,     0, 8'h00, 1'b1, 32'hdead_beef, 32'h0bad_cafe, 16'h0000,
          1'b0, STATUS_GOOD, 16'd0}
    };

    base_status_frame_receiver_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void note_fault(input frame_status_t status,
                                       output frame_result_t r);
        fault_total          = fault_total + 16'd1;
        r.status             = status;
        r.data               = '0;
        r.data.fault_count   = fault_total;
    endfunction

    function automatic bit predict_frame_byte(input logic [7:0] b, input logic st,
                                              output frame_result_t r);
        bit          produced;
        logic [31:0] left_now;
        logic [31:0] right_now;
        logic [15:0] heading_now;
        r.status = STATUS_GOOD;
        r.data   = '0;
        if (st)
        begin
            produced = (rx_pos != 0);
            if (produced)
                note_fault(STATUS_FRAMING, r);
            rx_copy[0] = b;
            rx_sum     = '0;
            rx_pos     = 5'd1;
            return produced;
        end
        if (rx_pos == 0 || rx_pos >= FRAME_LEN)
        begin
            rx_pos = '0;
            return 1'b0;
        end
        rx_copy[rx_pos] = b;
        if (rx_pos < CHECK_POS)
            rx_sum = rx_sum + b;
        if (rx_pos < LAST_POS)
        begin
            rx_pos = rx_pos + 5'd1;
            return 1'b0;
        end
        rx_pos = '0;
        if (rx_copy[0] != HEAD_BYTE || rx_copy[LAST_POS] != TAIL_BYTE)
            note_fault(STATUS_FRAMING, r);
        else if (rx_copy[CHECK_POS] != rx_sum)
            note_fault(STATUS_CHECKSUM, r);
        else
        begin
            left_now    = {rx_copy[9], rx_copy[10], rx_copy[11], rx_copy[12]};
            right_now   = {rx_copy[13], rx_copy[14], rx_copy[15], rx_copy[16]};
            heading_now = {rx_copy[17], rx_copy[18]};
            if (good_seen >= 2'd2)
            begin
                left_hold  = left_now - last_left;
                right_hold = last_right - right_now;
            end
            last_left  = left_now;
            last_right = right_now;
            if (good_seen == 2'd0)
            begin
                heading_ref            = heading_now;
                r.data.heading_offset  = '0;
            end
            else
                r.data.heading_offset  = heading_now - heading_ref;
            if (good_seen < 2'd2)
                good_seen = good_seen + 2'd1;
            r.data.ultrasonic_bytes = {rx_copy[1], rx_copy[2], rx_copy[3],
                                       rx_copy[4], rx_copy[5], rx_copy[6]};
            r.data.bumper_bits      = rx_copy[7];
            r.data.battery_level    = rx_copy[8];
            r.data.left_delta       = left_hold;
            r.data.right_delta      = right_hold;
            r.data.state_flags      = rx_copy[19];
            r.data.fault_count      = fault_total;
        end
        return 1'b1;
    endfunction

    function automatic frame_bytes_t build_frame(input stim_row_t row);
        frame_bytes_t f;
        logic [7:0]   sum;
        for (int i = 1; i <= 8; i++)
            f[i] = row.rand_fill ? 8'($urandom) : row.fill;
        f[19] = row.rand_fill ? 8'($urandom) : row.fill;
        {f[9], f[10], f[11], f[12]}  = row.left;
        {f[13], f[14], f[15], f[16]} = row.right;
        {f[17], f[18]}               = row.heading;
        sum = '0;
        for (int i = 1; i < CHECK_POS; i++)
            sum = sum + f[i];
        f[0]         = HEAD_BYTE;
        f[CHECK_POS] = sum;
        f[LAST_POS]  = TAIL_BYTE;
        if (row.kind == KIND_BAD_HEAD || row.kind == KIND_BAD_BOTH)
            f[0] = HEAD_BYTE ^ 8'($urandom_range(1, 255));
        if (row.kind == KIND_BAD_TAIL)
            f[LAST_POS] = TAIL_BYTE ^ 8'($urandom_range(1, 255));
        if (row.kind == KIND_BAD_SUM || row.kind == KIND_BAD_BOTH)
            f[CHECK_POS] = sum ^ 8'($urandom_range(1, 255));
        return f;
    endfunction

    function automatic logic [31:0] pick_count(input logic [31:0] prior);
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            3:       return 32'($urandom);
            default: return prior + 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic st);
        frame_result_t r;
        int unsigned   pause;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (pause != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do
            @(posedge clk);
        while (!s_tready);
        counted_bytes++;
        if (predict_frame_byte(b, st, r))
        begin
            if (typed_on && r.status != STATUS_GOOD)
            begin
                r.status           = typed_status;
                r.data             = '0;
                r.data.fault_count = typed_faults;
            end
            pending_frames.push_back(r);
        end
    endtask

    task automatic play_row(input stim_row_t row);
        frame_bytes_t f;
        typed_on     = row.typed;
        typed_status = row.t_status;
        typed_faults = row.t_faults;
        f = build_frame(row);
        case (row.kind)
            KIND_STRAY:
                repeat (row.len)
                    send_byte(8'($urandom), row.rand_fill && $urandom_range(0, 5) == 0);
            KIND_CUT:
                for (int i = 0; i < row.len; i++)
                    send_byte(f[i], i == 0);
            default:
            begin
                for (int i = 0; i < FRAME_LEN; i++)
                    send_byte(f[i], i == 0);
                if (row.kind == KIND_TRAILING)
                    repeat (row.len)
                        send_byte(8'($urandom), 1'b0);
            end
        endcase
        typed_on = 1'b0;
    endtask

    task automatic play_random_row(input frame_kind_t kind, input int unsigned len);
        stim_row_t row;
        gen_left      = pick_count(gen_left);
        gen_right     = pick_count(gen_right);
        row.kind      = kind;
        row.len       = len;
        row.fill      = 8'h00;
        row.rand_fill = 1'b1;
        row.left      = gen_left;
        row.right     = gen_right;
        row.heading   = 16'($urandom);
        row.typed     = 1'b0;
        row.t_status  = STATUS_GOOD;
        row.t_faults  = '0;
        play_row(row);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    task automatic check_result(input logic [1:0] status, input result_data_t d);
        frame_result_t e;
        if (pending_frames.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected, status %h", status));
            return;
        end
        e = pending_frames.pop_front();
        check_field("frame_status",     e.status,                status);
        check_field("ultrasonic_bytes", e.data.ultrasonic_bytes, d.ultrasonic_bytes);
        check_field("bumper_bits",      e.data.bumper_bits,      d.bumper_bits);
        check_field("battery_level",    e.data.battery_level,    d.battery_level);
        check_field("left_delta",       e.data.left_delta,       d.left_delta);
        check_field("right_delta",      e.data.right_delta,      d.right_delta);
        check_field("heading_offset",   e.data.heading_offset,   d.heading_offset);
        check_field("state_flags",      e.data.state_flags,      d.state_flags);
        check_field("fault_count",      e.data.fault_count,      d.fault_count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tuser, result_data_t'(m_tdata));
    end

    always @(posedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode <= $urandom_range(0, 2);
            rdy_left <= $urandom_range(20, 200);
        end
        else
            rdy_left <= rdy_left - 1;
        rdy_phase <= rdy_phase + 1;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((rdy_phase % 5) < 2);
        endcase
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            play_row(directed_rows[i]);

        while (counted_bytes < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                play_random_row(KIND_GOOD, 0);
            else if (pick < 66)
                play_random_row(KIND_BAD_HEAD, 0);
            else if (pick < 71)
                play_random_row(KIND_BAD_TAIL, 0);
            else if (pick < 77)
                play_random_row(KIND_BAD_SUM, 0);
            else if (pick < 80)
                play_random_row(KIND_BAD_BOTH, 0);
            else if (pick < 90)
                play_random_row(KIND_CUT, $urandom_range(1, 21));
            else if (pick < 95)
                play_random_row(KIND_STRAY, $urandom_range(1, 10));
            else
                play_random_row(KIND_TRAILING, $urandom_range(1, 3));
        end

        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_frames.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: base_status_frame_receiver_unit.f
src/bsfr_pkg.sv
src/base_status_frame_receiver_unit.sv
tb/sv/tb_base_status_frame_receiver_unit.sv
